// File: sv/pls_pkg.sv
// pls_pkg: shared sizes, op codes, status codes and the control struct
// for the positional list store; no dependencies
`default_nettype none

package pls_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the request and response
    localparam int OP_W     = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // internal widths derived from the capacity and the position width
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT    = 4'd0,
        OP_ADD_REAR     = 4'd1,
        OP_ADD_AT       = 4'd2,
        OP_GET_FRONT    = 4'd3,
        OP_GET_REAR     = 4'd4,
        OP_GET_AT       = 4'd5,
        OP_SET_FRONT    = 4'd6,
        OP_SET_REAR     = 4'd7,
        OP_SET_AT       = 4'd8,
        OP_REMOVE_FRONT = 4'd9,
        OP_REMOVE_REAR  = 4'd10
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_req;  // capture the accepted request
        logic exec;      // carry out the held request, load the result register
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/pls_ctrl.sv
// pls_ctrl: request sequencer and output valid tracking
// depends on pls_pkg
`default_nettype none

module pls_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output pls_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_req = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_EXEC) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/pls_dp.sv
// pls_dp: entry cells with parallel shift, entry count, decode and
// result register; depends on pls_pkg
`default_nettype none

module pls_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pls_pkg::t_cmd                     i_cmd,
    input  wire logic [pls_pkg::OP_W-1:0]          i_op,
    input  wire logic [pls_pkg::VALUE_W-1:0]       i_value,
    input  wire logic [pls_pkg::POS_W-1:0]         i_position,
    output logic      [pls_pkg::VALUE_W-1:0]       o_read_value,
    output logic      [pls_pkg::STATUS_W-1:0]      o_status,
    output logic      [pls_pkg::COUNT_W-1:0]       o_count
);

    localparam int CAP  = pls_pkg::CAPACITY;
    localparam int DW   = pls_pkg::DATA_WIDTH;
    localparam int VW   = pls_pkg::VALUE_W;
    localparam int CMPW = pls_pkg::CMP_W;
    localparam int CW   = pls_pkg::CNT_W;
    localparam int IW   = pls_pkg::IDX_W;
    localparam int OW   = pls_pkg::COUNT_W;

    typedef enum logic [2:0] {
        K_NONE,
        K_INSERT,
        K_READ,
        K_WRITE,
        K_REMOVE
    } t_kind;

    // held request
    logic [pls_pkg::OP_W-1:0]  r_op;
    logic [DW-1:0]             r_word;
    logic [pls_pkg::POS_W-1:0] r_pos;

    logic [DW-1:0] r_cells [CAP];
    logic [DW-1:0] n_cells [CAP];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic [VW-1:0]                r_read_value;
    logic [pls_pkg::STATUS_W-1:0] r_status;
    logic [OW-1:0]                r_count_out;

    logic [CMPW-1:0]      cnt_x;
    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      at;
    logic                 full;
    logic                 empty;
    t_kind                kind;
    pls_pkg::t_status     status;
    logic [DW-1:0]        sel_word;
    logic [VW+DW-1:0]     rd_ext;
    logic [VW-1:0]        rd;
    logic [DW+VW-1:0]     word_ext;
    logic [CW+OW-1:0]     cnt_ext;

    assign word_ext = {{DW{1'b0}}, i_value};

    assign cnt_x = CMPW'(r_count);
    assign pos_x = CMPW'(r_pos);
    assign full  = (r_count >= CW'(CAP));
    assign empty = (r_count == '0);

    // decode: target position, status and kind of change
    always_comb begin
        at     = '0;
        kind   = K_NONE;
        status = pls_pkg::ST_OK;
        unique case (r_op)
            pls_pkg::OP_ADD_FRONT, pls_pkg::OP_ADD_REAR, pls_pkg::OP_ADD_AT: begin
                if (r_op == pls_pkg::OP_ADD_FRONT) begin
                    at = '0;
                end else if (r_op == pls_pkg::OP_ADD_REAR) begin
                    at = cnt_x;
                end else begin
                    at = pos_x;
                end
                if (at > cnt_x) begin
                    status = pls_pkg::ST_RANGE;
                end else if (full) begin
                    status = pls_pkg::ST_FULL;
                end else begin
                    kind = K_INSERT;
                end
            end
            pls_pkg::OP_GET_FRONT, pls_pkg::OP_SET_FRONT, pls_pkg::OP_REMOVE_FRONT,
            pls_pkg::OP_GET_REAR, pls_pkg::OP_SET_REAR, pls_pkg::OP_REMOVE_REAR: begin
                if (r_op == pls_pkg::OP_GET_FRONT || r_op == pls_pkg::OP_SET_FRONT ||
                    r_op == pls_pkg::OP_REMOVE_FRONT) begin
                    at = '0;
                end else begin
                    at = cnt_x - CMPW'(1);
                end
                if (empty) begin
                    status = pls_pkg::ST_EMPTY;
                end else if (r_op == pls_pkg::OP_GET_FRONT ||
                             r_op == pls_pkg::OP_GET_REAR) begin
                    kind = K_READ;
                end else if (r_op == pls_pkg::OP_SET_FRONT ||
                             r_op == pls_pkg::OP_SET_REAR) begin
                    kind = K_WRITE;
                end else begin
                    kind = K_REMOVE;
                end
            end
            pls_pkg::OP_GET_AT, pls_pkg::OP_SET_AT: begin
                at = pos_x;
                if (pos_x >= cnt_x) begin
                    status = pls_pkg::ST_RANGE;
                end else if (r_op == pls_pkg::OP_GET_AT) begin
                    kind = K_READ;
                end else begin
                    kind = K_WRITE;
                end
            end
            default: begin
                kind = K_NONE;
            end
        endcase
    end

    // read port: position is below count whenever it is used
    assign sel_word = r_cells[at[IW-1:0]];
    assign rd_ext   = {{VW{1'b0}}, sel_word};
    assign rd       = (kind == K_READ || kind == K_REMOVE) ? rd_ext[VW-1:0] : '0;

    // parallel shift of every cell
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_cells[i] = r_cells[i];
            unique case (kind)
                K_INSERT: begin
                    if (CMPW'(i) == at) begin
                        n_cells[i] = r_word;
                    end else if (CMPW'(i) > at) begin
                        n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                    end
                end
                K_WRITE: begin
                    if (CMPW'(i) == at) begin
                        n_cells[i] = r_word;
                    end
                end
                K_REMOVE: begin
                    if (CMPW'(i) >= at && i + 1 < CAP) begin
                        n_cells[i] = r_cells[(i + 1 < CAP) ? i + 1 : i];
                    end
                end
                default: begin
                    n_cells[i] = r_cells[i];
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (kind == K_INSERT) begin
            n_count = r_count + CW'(1);
        end else if (kind == K_REMOVE) begin
            n_count = r_count - CW'(1);
        end
    end

    assign cnt_ext = {{OW{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op   <= i_op;
            r_word <= word_ext[DW-1:0];
            r_pos  <= i_position;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAP; i++) begin
                r_cells[i] <= n_cells[i];
            end
            r_read_value <= rd;
            r_status     <= status;
            r_count_out  <= cnt_ext[OW-1:0];
        end
    end

    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;

endmodule

`default_nettype wire

// File: sv/positional_list_store.sv
// request flow: an accepted request is captured in the hold register, then executed
//   into the result register; a new request is taken only after the held one has run,
//   in the controller's accept then execute sequence; a waiting result stalls only the execute step
// reset: entry count and handshake state clear, entry cells keep garbage
//   and are never read before written, so there is no clearing pass
`default_nettype none

module positional_list_store (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [pls_pkg::OP_W-1:0]          i_op,
    input  wire logic [pls_pkg::VALUE_W-1:0]       i_value,
    input  wire logic [pls_pkg::POS_W-1:0]         i_position,
    // response channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [pls_pkg::VALUE_W-1:0]       o_read_value,
    output logic      [pls_pkg::STATUS_W-1:0]      o_status,
    output logic      [pls_pkg::COUNT_W-1:0]       o_count
);

    // command bundle from the sequencer to the datapath
    pls_pkg::t_cmd cmd;

    // sequencer: takes one transfer, then executes it once the result
    // register is free or being emptied this cycle
    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // datapath: request hold register, entry cells that shift up or down
    // by one place in parallel, entry count and result register
    pls_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the positional list store, driving requests
// at random rates and checking every response; depends on pls_pkg and the rtl
module tb_top;

    localparam int RANDOM_REQUESTS = 1050;
    localparam int IDLE_LIMIT      = 2000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES    = 20;    // quiet time after the last response
    localparam int PRINT_CAP       = 40;

    typedef logic [pls_pkg::OP_W-1:0]  t_op_bits;
    typedef logic [pls_pkg::POS_W-1:0] t_pos_bits;

    typedef struct {
        logic [pls_pkg::OP_W-1:0]    op;
        logic [pls_pkg::VALUE_W-1:0] value;
        logic [pls_pkg::POS_W-1:0]   position;
    } t_request;

    typedef struct {
        logic [pls_pkg::VALUE_W-1:0]  read_value;
        logic [pls_pkg::STATUS_W-1:0] status;
        logic [pls_pkg::COUNT_W-1:0]  count;
    } t_response;

    // dut inputs, all known from time zero
    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         i_out_stall  = 1'b0;
    logic [pls_pkg::OP_W-1:0]     i_op         = '0;
    logic [pls_pkg::VALUE_W-1:0]  i_value      = '0;
    logic [pls_pkg::POS_W-1:0]    i_position   = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [pls_pkg::VALUE_W-1:0]  o_read_value;
    logic [pls_pkg::STATUS_W-1:0] o_status;
    logic [pls_pkg::COUNT_W-1:0]  o_count;

    // requests waiting to be driven, responses waiting to arrive
    t_request  request_queue[$];
    t_response response_queue[$];

    // shadow copy of the list contents, updated as each request transfers
    logic [pls_pkg::DATA_WIDTH-1:0] list_words[pls_pkg::CAPACITY];
    int unsigned                    list_len = 0;
    int unsigned                    peak_len = 0;

    int unsigned gen_len        = 0;  // list length as the stimulus builder sees it
    int          error_count    = 0;
    int          requests_sent  = 0;
    int          responses_seen = 0;
    int          status_tally[4] = '{default: 0};
    int          send_gap       = 0;
    int          hold_left      = 0;
    bit          send_burst     = 1'b0;
    bit          hold_burst     = 1'b0;
    int          idle_cycles    = 0;
    t_request    held_request;

    positional_list_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
            $display("%0t ns response %0d: %s", $time, responses_seen, what);
        error_count++;
    endtask

    // queue a request and keep the builder's idea of the list length current,
    // so positions can be aimed at the live part of the list
    task automatic push_request(input logic [pls_pkg::OP_W-1:0] op,
                                input logic [pls_pkg::VALUE_W-1:0] value,
                                input logic [pls_pkg::POS_W-1:0] position);
        t_request req;
        req.op       = op;
        req.value    = value;
        req.position = position;
        request_queue.push_back(req);
        case (op)
            pls_pkg::OP_ADD_FRONT, pls_pkg::OP_ADD_REAR:
                if (gen_len < pls_pkg::CAPACITY) gen_len++;
            pls_pkg::OP_ADD_AT:
                if (position <= gen_len && gen_len < pls_pkg::CAPACITY) gen_len++;
            pls_pkg::OP_REMOVE_FRONT, pls_pkg::OP_REMOVE_REAR:
                if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endtask

    // work out the response to one transferred request and apply it to the
    // shadow list; inserts and removals shift the tail by one place
    task automatic predict_response(input t_request req);
        t_response    rsp;
        pls_pkg::t_op code;
        int unsigned  at;
        int           i;
        rsp.read_value = '0;
        rsp.status     = pls_pkg::ST_OK;
        code = pls_pkg::t_op'(req.op);
        case (code)
            pls_pkg::OP_ADD_FRONT, pls_pkg::OP_ADD_REAR, pls_pkg::OP_ADD_AT: begin
                at = (code == pls_pkg::OP_ADD_FRONT) ? 0 :
                     (code == pls_pkg::OP_ADD_REAR) ? list_len : req.position;
                // position check wins over the full check
                if (at > list_len) begin
                    rsp.status = pls_pkg::ST_RANGE;
                end else if (list_len >= pls_pkg::CAPACITY) begin
                    rsp.status = pls_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = req.value;
                    list_len++;
                end
            end
            pls_pkg::OP_GET_FRONT, pls_pkg::OP_GET_REAR, pls_pkg::OP_SET_FRONT,
            pls_pkg::OP_SET_REAR, pls_pkg::OP_REMOVE_FRONT, pls_pkg::OP_REMOVE_REAR: begin
                if (list_len == 0) begin
                    rsp.status = pls_pkg::ST_EMPTY;
                end else begin
                    at = (code == pls_pkg::OP_GET_FRONT || code == pls_pkg::OP_SET_FRONT ||
                          code == pls_pkg::OP_REMOVE_FRONT) ? 0 : list_len - 1;
                    if (code == pls_pkg::OP_GET_FRONT || code == pls_pkg::OP_GET_REAR) begin
                        rsp.read_value = list_words[at];
                    end else if (code == pls_pkg::OP_SET_FRONT ||
                                 code == pls_pkg::OP_SET_REAR) begin
                        list_words[at] = req.value;
                    end else begin
                        rsp.read_value = list_words[at];
                        for (i = at; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            pls_pkg::OP_GET_AT, pls_pkg::OP_SET_AT: begin
                // also out of range on an empty list
                if (req.position >= list_len)
                    rsp.status = pls_pkg::ST_RANGE;
                else if (code == pls_pkg::OP_GET_AT)
                    rsp.read_value = list_words[req.position];
                else
                    list_words[req.position] = req.value;
            end
            default: ;  // unused codes leave the list alone
        endcase
        rsp.count = list_len[pls_pkg::COUNT_W-1:0];
        if (list_len > peak_len) peak_len = list_len;
        status_tally[rsp.status]++;
        response_queue.push_back(rsp);
    endtask

    // request driver: one transfer per item, a random gap before the next,
    // with stretches of back-to-back items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_response(held_request);
                requests_sent++;
            end
            // payload may only move once the current one has transferred
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    held_request = request_queue.pop_front();
                    i_op       <= held_request.op;
                    i_value    <= held_request.value;
                    i_position <= held_request.position;
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 15);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor: checks each transfer against the oldest prediction,
    // then holds stall for a randomly drawn number of cycles
    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                responses_seen++;
                if (response_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected response value %h status %0d count %0d",
                                              o_read_value, o_status, o_count));
                end else begin
                    want = response_queue.pop_front();
                    if (o_read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, predicted %h",
                                                  o_read_value, want.read_value));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  o_status, want.status));
                    if (o_count !== want.count)
                        report_mismatch($sformatf("count %0d, predicted %0d",
                                                  o_count, want.count));
                end
                if ($urandom_range(0, 39) == 0) hold_burst = !hold_burst;
                hold_left = hold_burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: any transfer on either side resets the idle count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transfer for %0d cycles, %0d responses outstanding",
                         IDLE_LIMIT, response_queue.size());
                $display("positional_list_store: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int          produced;
        int          phase_kind;
        int          phase_len;
        int          j;
        int          roll;
        logic [pls_pkg::OP_W-1:0]    op;
        logic [pls_pkg::VALUE_W-1:0] value;
        logic [pls_pkg::POS_W-1:0]   position;

        // directed: every empty-list case first, then a short list of four
        push_request(pls_pkg::OP_GET_FRONT,    32'h0,         '0);
        push_request(pls_pkg::OP_GET_REAR,     32'h0,         '0);
        push_request(pls_pkg::OP_SET_FRONT,    32'h1234_5678, '0);
        push_request(pls_pkg::OP_SET_REAR,     32'h8765_4321, '1);
        push_request(pls_pkg::OP_REMOVE_FRONT, 32'h0,         '0);
        push_request(pls_pkg::OP_REMOVE_REAR,  32'h0,         '1);
        push_request(pls_pkg::OP_GET_AT,       32'h0,         '0);  // empty and out of range
        push_request(pls_pkg::OP_SET_AT,       '1,            '1);
        push_request(pls_pkg::OP_ADD_AT,       32'hdead_beef, 5'd1);  // beyond count
        push_request('1,                       '1,            '1);  // unused codes
        push_request(t_op_bits'(pls_pkg::OP_REMOVE_REAR + 1), 32'h0, '0);
        push_request(pls_pkg::OP_ADD_FRONT,    '1,            '1);
        push_request(pls_pkg::OP_ADD_REAR,     '0,            '0);
        push_request(pls_pkg::OP_ADD_AT,       32'ha5a5_a5a5, 5'd1);
        push_request(pls_pkg::OP_ADD_AT,       32'h5a5a_5a5a, 5'd3);  // at count, lands at rear
        push_request(pls_pkg::OP_GET_AT,       32'h0,         '1);
        push_request(pls_pkg::OP_GET_AT,       32'h0,         5'd4);  // exactly count
        push_request(pls_pkg::OP_GET_FRONT,    32'h0,         '0);
        push_request(pls_pkg::OP_GET_REAR,     32'h0,         '0);
        push_request(pls_pkg::OP_GET_AT,       32'h0,         5'd2);
        push_request(pls_pkg::OP_SET_AT,       32'h0f0f_0f0f, 5'd3);
        push_request(pls_pkg::OP_SET_FRONT,    32'h0000_0001, '0);
        push_request(pls_pkg::OP_SET_REAR,     32'h8000_0000, '0);
        push_request(pls_pkg::OP_REMOVE_FRONT, 32'h0,         '0);
        push_request(pls_pkg::OP_REMOVE_REAR,  32'h0,         '0);

        // random: phases that grow the list to full, drain it to empty,
        // mix everything, or throw raw noise at it
        produced = 0;
        while (produced < RANDOM_REQUESTS) begin
            phase_kind = $urandom_range(0, 3);
            phase_len  = $urandom_range(20, 60);
            for (j = 0; j < phase_len && produced < RANDOM_REQUESTS; j++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: begin  // grow
                        if (roll < 70)
                            op = t_op_bits'($urandom_range(pls_pkg::OP_ADD_FRONT,
                                                           pls_pkg::OP_ADD_AT));
                        else if (roll < 90)
                            op = t_op_bits'($urandom_range(pls_pkg::OP_GET_FRONT,
                                                           pls_pkg::OP_SET_AT));
                        else
                            op = t_op_bits'($urandom_range(pls_pkg::OP_REMOVE_FRONT,
                                                           pls_pkg::OP_REMOVE_REAR));
                    end
                    1: begin  // shrink
                        if (roll < 55)
                            op = t_op_bits'($urandom_range(pls_pkg::OP_REMOVE_FRONT,
                                                           pls_pkg::OP_REMOVE_REAR));
                        else if (roll < 85)
                            op = t_op_bits'($urandom_range(pls_pkg::OP_GET_FRONT,
                                                           pls_pkg::OP_SET_AT));
                        else
                            op = t_op_bits'($urandom_range(pls_pkg::OP_ADD_FRONT,
                                                           pls_pkg::OP_ADD_AT));
                    end
                    2: op = t_op_bits'($urandom_range(pls_pkg::OP_ADD_FRONT,
                                                      pls_pkg::OP_REMOVE_REAR));
                    default: op = t_op_bits'($urandom_range(0, (1 << pls_pkg::OP_W) - 1));
                endcase
                if (phase_kind != 3 && $urandom_range(0, 99) < 3)
                    op = t_op_bits'($urandom_range(pls_pkg::OP_REMOVE_REAR + 1,
                                                   (1 << pls_pkg::OP_W) - 1));

                // positional ops mostly aim inside the list, now and then anywhere
                position = t_pos_bits'($urandom_range(0, (1 << pls_pkg::POS_W) - 1));
                if (phase_kind != 3 && $urandom_range(0, 99) >= 10) begin
                    if (op == pls_pkg::OP_ADD_AT)
                        position = t_pos_bits'($urandom_range(0, gen_len));
                    else if ((op == pls_pkg::OP_GET_AT || op == pls_pkg::OP_SET_AT) &&
                             gen_len > 0)
                        position = t_pos_bits'($urandom_range(0, gen_len - 1));
                end

                roll = $urandom_range(0, 99);
                value = (roll < 5) ? '0 : (roll < 10) ? '1 : $urandom;
                push_request(op, value, position);
                produced++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every request transferred and every response checked
        while (request_queue.size() > 0 || i_in_valid || response_queue.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d responses; peak list length %0d of %0d",
                 requests_sent, responses_seen, peak_len, pls_pkg::CAPACITY);
        $display("status ok %0d, empty %0d, out of range %0d, full %0d",
                 status_tally[pls_pkg::ST_OK], status_tally[pls_pkg::ST_EMPTY],
                 status_tally[pls_pkg::ST_RANGE], status_tally[pls_pkg::ST_FULL]);
        if (error_count == 0)
            $display("positional_list_store: match");
        else
            $display("positional_list_store: mismatch");
        $finish;
    end

endmodule
